### rtl/ats_pkg.sv
// Shared types and constants of the alarm tone sequencer.
package ats_pkg;

    localparam int unsigned DIV_W   = 33;
    localparam int unsigned REM_W   = 17;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned IDX_W   = 3;

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);

    localparam logic [7:0]  MODE_BEEP      = 8'd1;
    localparam logic [7:0]  MODE_SIREN     = 8'd2;
    localparam logic [7:0]  LAST_MODE_RST  = 8'd255;
    localparam logic [7:0]  COMPARE_RST    = 8'd200;
    localparam logic [7:0]  MAX_COMPARE    = 8'd255;
    localparam logic [16:0] MIN_TONE_HZ    = 17'd100;

    localparam logic [15:0] SWEEP_LOW_RST  = 16'd600;
    localparam logic [15:0] SWEEP_HIGH_RST = 16'd1800;
    localparam logic [15:0] BEEP_HZ_RST    = 16'd1200;
    localparam logic [15:0] SWEEP_HALF_RST = 16'd1000;
    localparam logic [15:0] BEEP_HALF_RST  = 16'd200;
    localparam logic [23:0] TIMER_BASE_RST = 24'd125000;

    typedef enum logic [IDX_W-1:0] {
        REG_SWEEP_LOW  = 3'd0,
        REG_SWEEP_HIGH = 3'd1,
        REG_BEEP_HZ    = 3'd2,
        REG_SWEEP_HALF = 3'd3,
        REG_BEEP_HALF  = 3'd4,
        REG_TIMER_BASE = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TRI,
        S_MUL,
        S_SCALE,
        S_FREQ,
        S_CMP,
        S_DONE
    } t_state;

endpackage

### rtl/ats_ifs.sv
// Handshake interfaces of the alarm tone sequencer: input, result and register write.
interface ats_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  alarm_mode;
    logic [31:0] now_ms;

    modport source (output valid, alarm_mode, now_ms, input ready);
    modport sink   (input valid, alarm_mode, now_ms, output ready);
endinterface

interface ats_out_if;
    logic       valid;
    logic       ready;
    logic       tone_on;
    logic [7:0] compare_value;

    modport source (output valid, tone_on, compare_value, input ready);
    modport sink   (input valid, tone_on, compare_value, output ready);
endinterface

interface ats_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/alarm_tone_sequencer_core.sv
// Alarm tone sequencer: per-update tone enable and timer compare value.
// Takes one update (mode, time in ms) and returns one result. All division goes
// through a single radix-2 restoring divider, used for the modulo, the sweep
// scaling and the compare in siren mode, for the modulo and the compare in beep
// mode while the tone is on, for the modulo alone while it is off, and not at all in any other mode.
// Input ready is low from the transfer until the result enters the output
// register; the next update may then be taken while that result still waits.
module alarm_tone_sequencer_core
    import ats_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ats_in_if.sink    i_in,
    ats_out_if.source o_out,
    ats_cfg_if.sink   i_cfg
);

    logic [15:0] r_sweep_low, r_sweep_high, r_beep_hz, r_sweep_half, r_beep_half;
    logic [23:0] r_timer_base;

    logic [7:0]  r_last_mode, n_last_mode;
    logic [31:0] r_start, n_start;
    logic [7:0]  r_last_cmp, n_last_cmp;

    t_state      r_state, n_state;
    logic        r_siren, n_siren;
    logic        r_on, n_on;
    logic [15:0] r_half, n_half;
    logic [15:0] r_tri, n_tri;

    logic [DIV_W-1:0] r_dq, n_dq;
    logic [REM_W-1:0] r_dr, n_dr;
    logic [REM_W-1:0] r_dd, n_dd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic r_out_valid, n_out_valid;
    logic r_out_on, n_out_on;

    logic             in_xfer;
    logic             out_free;
    logic             t_lt_half;
    logic [REM_W:0]   div_shift;
    logic             div_ge;
    logic [REM_W:0]   div_diff;
    logic [15:0]      in_half_raw;
    logic [15:0]      in_half;
    logic [15:0]      span;
    logic [16:0]      freq;
    logic [16:0]      beep_f;
    logic [23:0]      quot;
    logic [7:0]       cmp_val;

    assign i_cfg.ready    = 1'b1;
    assign i_in.ready     = (r_state == S_IDLE);
    assign in_xfer        = i_in.valid && i_in.ready;
    assign out_free       = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.tone_on       = r_out_on;
    assign o_out.compare_value = r_last_cmp;

    assign in_half_raw = (i_in.alarm_mode == MODE_SIREN) ? r_sweep_half : r_beep_half;
    assign in_half     = (in_half_raw == 16'd0) ? 16'd1 : in_half_raw;

    assign div_shift = {r_dr, r_dq[DIV_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_dd};
    assign div_diff  = div_shift - {1'b0, r_dd};

    assign t_lt_half = r_dr < {1'b0, r_half};
    assign span      = (r_sweep_high >= r_sweep_low) ? (r_sweep_high - r_sweep_low) : 16'd0;
    assign freq      = {1'b0, r_sweep_low} + r_dq[16:0];
    assign beep_f    = {1'b0, r_beep_hz};
    assign quot      = r_dq[23:0];

    always_comb begin
        if (quot == 24'd0) begin
            cmp_val = 8'd0;
        end else if (quot > 24'd256) begin
            cmp_val = MAX_COMPARE;
        end else begin
            cmp_val = 8'(quot - 24'd1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.alarm_mode == MODE_SIREN || i_in.alarm_mode == MODE_BEEP) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (r_cnt == '0) n_state = S_TRI;
            end
            S_TRI: begin
                if (r_siren) begin
                    n_state = S_MUL;
                end else if (t_lt_half) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: n_state = S_SCALE;
            S_SCALE: begin
                if (r_cnt == '0) n_state = S_FREQ;
            end
            S_FREQ: n_state = S_CMP;
            S_CMP: begin
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_last_mode = r_last_mode;
        n_start     = r_start;
        n_last_cmp  = r_last_cmp;
        n_siren     = r_siren;
        n_on        = r_on;
        n_half      = r_half;
        n_tri       = r_tri;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dd        = r_dd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_on    = r_out_on;

        if (r_cnt != '0) begin
            n_dr  = div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
            n_dq  = {r_dq[DIV_W-2:0], div_ge};
            n_cnt = r_cnt - 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_siren = (i_in.alarm_mode == MODE_SIREN);
                    n_on    = 1'b0;
                    n_half  = in_half;
                    n_dr    = '0;
                    n_dd    = {in_half, 1'b0};
                    if (i_in.alarm_mode == MODE_SIREN || i_in.alarm_mode == MODE_BEEP) begin
                        n_cnt = DIV_STEPS;
                    end else begin
                        n_cnt = '0;
                    end
                    if (i_in.alarm_mode != r_last_mode) begin
                        n_last_mode = i_in.alarm_mode;
                        n_start     = i_in.now_ms;
                        n_dq        = '0;
                    end else begin
                        n_dq = {1'b0, i_in.now_ms - r_start};
                    end
                end
            end
            S_TRI: begin
                n_tri = t_lt_half ? r_dr[15:0] : 16'({r_half, 1'b0} - r_dr);
                if (!r_siren && t_lt_half) begin
                    n_on  = 1'b1;
                    n_dq  = {9'd0, r_timer_base};
                    n_dr  = '0;
                    n_dd  = (beep_f < MIN_TONE_HZ) ? MIN_TONE_HZ : beep_f;
                    n_cnt = DIV_STEPS;
                end
            end
            S_MUL: begin
                n_dq  = {1'b0, 32'(span) * 32'(r_tri)};
                n_dr  = '0;
                n_dd  = {1'b0, r_half};
                n_cnt = DIV_STEPS;
            end
            S_FREQ: begin
                n_on  = 1'b1;
                n_dq  = {9'd0, r_timer_base};
                n_dr  = '0;
                n_dd  = (freq < MIN_TONE_HZ) ? MIN_TONE_HZ : freq;
                n_cnt = DIV_STEPS;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_on    = r_on;
                    if (r_on) n_last_cmp = cmp_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_low  <= SWEEP_LOW_RST;
            r_sweep_high <= SWEEP_HIGH_RST;
            r_beep_hz    <= BEEP_HZ_RST;
            r_sweep_half <= SWEEP_HALF_RST;
            r_beep_half  <= BEEP_HALF_RST;
            r_timer_base <= TIMER_BASE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_SWEEP_LOW:  r_sweep_low  <= i_cfg.data[15:0];
                REG_SWEEP_HIGH: r_sweep_high <= i_cfg.data[15:0];
                REG_BEEP_HZ:    r_beep_hz    <= i_cfg.data[15:0];
                REG_SWEEP_HALF: r_sweep_half <= i_cfg.data[15:0];
                REG_BEEP_HALF:  r_beep_half  <= i_cfg.data[15:0];
                REG_TIMER_BASE: r_timer_base <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_mode <= LAST_MODE_RST;
            r_start     <= '0;
            r_last_cmp  <= COMPARE_RST;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_mode <= n_last_mode;
            r_start     <= n_start;
            r_last_cmp  <= n_last_cmp;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_siren  <= n_siren;
        r_on     <= n_on;
        r_half   <= n_half;
        r_tri    <= n_tri;
        r_dq     <= n_dq;
        r_dr     <= n_dr;
        r_dd     <= n_dd;
        r_out_on <= n_out_on;
    end

`ifndef SYNTHESIS
    a_div_only_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_MOD || r_state == S_SCALE || r_state == S_CMP))
        else $error("divider stepping outside a divide state");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("sequencer idle right after input transfer");

    a_cmp_only_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_last_cmp))
        else $error("compare value changed outside result stage");
`endif

endmodule

### sim/alarm_tone_sequencer_core_test.sv
// Self-checking testbench for the alarm tone sequencer core: directed and random updates.
module alarm_tone_sequencer_core_test;
    import ats_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 150;

    typedef struct packed {
        logic       tone_on;
        logic [7:0] compare_value;
    } t_tone;

    logic i_clk;
    logic i_rst_n;

    ats_in_if  upd_if();
    ats_out_if tone_if();
    ats_cfg_if reg_if();

    alarm_tone_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (upd_if),
        .o_out   (tone_if),
        .i_cfg   (reg_if)
    );

    // register shadow and sequencer state
    logic [15:0] low_hz, high_hz, beep_tone_hz, sweep_half, beep_half;
    logic [23:0] base_hz;
    logic [7:0]  seen_mode;
    logic [31:0] mode_origin_ms;
    logic [7:0]  held_compare;

    t_tone       tone_queue[$];
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned errors;
    int unsigned updates_sent;
    int unsigned tones_checked;
    int unsigned reg_writes;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] freq_to_compare(input logic [31:0] freq);
        logic [31:0] f;
        logic [31:0] q;
        f = (freq < 32'(MIN_TONE_HZ)) ? 32'(MIN_TONE_HZ) : freq;
        q = 32'(base_hz) / f;
        if (q == 0) begin
            q = 1;
        end
        q = q - 1;
        if (q > 32'(MAX_COMPARE)) begin
            q = 32'(MAX_COMPARE);
        end
        return q[7:0];
    endfunction

    function automatic t_tone predict_tone(input logic [7:0] mode, input logic [31:0] now);
        logic [31:0] elapsed, half, t, tri_pos, span, freq;
        logic [63:0] prod;
        t_tone r;
        if (mode != seen_mode) begin
            seen_mode = mode;
            mode_origin_ms = now;
        end
        elapsed = now - mode_origin_ms;
        r.tone_on = 1'b0;
        if (mode == MODE_SIREN) begin
            half = (sweep_half == 0) ? 32'd1 : 32'(sweep_half);
            t = elapsed % (2 * half);
            tri_pos = (t < half) ? t : (2 * half - t);
            span = (high_hz >= low_hz) ? 32'(high_hz - low_hz) : 32'd0;
            prod = 64'(span) * 64'(tri_pos);
            freq = 32'(low_hz) + 32'(prod / 64'(half));
            held_compare = freq_to_compare(freq);
            r.tone_on = 1'b1;
        end else if (mode == MODE_BEEP) begin
            half = (beep_half == 0) ? 32'd1 : 32'(beep_half);
            t = elapsed % (2 * half);
            if (t < half) begin
                held_compare = freq_to_compare(32'(beep_tone_hz));
                r.tone_on = 1'b1;
            end
        end
        r.compare_value = held_compare;
        return r;
    endfunction

    task automatic send_update(input logic [7:0] mode, input logic [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            upd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        upd_if.valid      <= 1'b1;
        upd_if.alarm_mode <= mode;
        upd_if.now_ms     <= now;
        @(posedge i_clk);
        while (!upd_if.ready) begin
            @(posedge i_clk);
        end
        tone_queue.push_back(predict_tone(mode, now));
        updates_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        upd_if.valid <= 1'b0;
        while (tone_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [23:0] value);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= value;
        @(posedge i_clk);
        while (!reg_if.ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_SWEEP_LOW:  low_hz       = value[15:0];
            REG_SWEEP_HIGH: high_hz      = value[15:0];
            REG_BEEP_HZ:    beep_tone_hz = value[15:0];
            REG_SWEEP_HALF: sweep_half   = value[15:0];
            REG_BEEP_HALF:  beep_half    = value[15:0];
            REG_TIMER_BASE: base_hz      = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        reg_if.valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] beep, input logic [15:0] s_half,
                                 input logic [15:0] b_half, input logic [23:0] base);
        drain_results();
        write_reg(REG_SWEEP_LOW, 24'(lo));
        write_reg(REG_SWEEP_HIGH, 24'(hi));
        write_reg(REG_BEEP_HZ, 24'(beep));
        write_reg(REG_SWEEP_HALF, 24'(s_half));
        write_reg(REG_BEEP_HALF, 24'(b_half));
        write_reg(REG_TIMER_BASE, base);
    endtask

    // runs of one mode with advancing time, plus scattered noise updates
    task automatic run_traffic(input int unsigned count);
        int unsigned sent, pick, run_len, period;
        logic [7:0]  mode;
        logic [31:0] now;
        bit          paused;
        sent = 0;
        paused = 1'b0;
        while (sent < count) begin
            if ($urandom_range(99) < 12) begin
                send_update(8'($urandom()), $urandom());
                sent++;
            end else begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    mode = MODE_SIREN;
                end else if (pick < 80) begin
                    mode = MODE_BEEP;
                end else if (pick < 90) begin
                    mode = 8'd0;
                end else begin
                    mode = 8'($urandom());
                end
                if (mode == MODE_SIREN) begin
                    period = 2 * ((sweep_half == 0) ? 1 : int'(sweep_half));
                end else if (mode == MODE_BEEP) begin
                    period = 2 * ((beep_half == 0) ? 1 : int'(beep_half));
                end else begin
                    period = 64;
                end
                now = $urandom();
                run_len = $urandom_range(2, 12);
                repeat (run_len) begin
                    send_update(mode, now);
                    sent++;
                    if ($urandom_range(99) < 10) begin
                        now = now + $urandom();
                    end else begin
                        now = now + $urandom_range(0, period / 3 + 1);
                    end
                end
            end
            if (!paused && sent >= count / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_default_sweep_and_beep();
        // reset mode value seen first: no change, start stays 0
        send_update(8'd255, 32'd5);
        send_update(MODE_SIREN, 32'h0000_1000);
        send_update(MODE_SIREN, 32'h0000_1000 + 32'd500);
        send_update(MODE_SIREN, 32'h0000_1000 + 32'd1000);
        send_update(MODE_SIREN, 32'h0000_1000 + 32'd1999);
        // elapsed time wrapping through zero
        send_update(8'd0, 32'hFFFF_FF00);
        send_update(MODE_SIREN, 32'hFFFF_FE00);
        send_update(MODE_SIREN, 32'h0000_0300);
        send_update(MODE_BEEP, 32'h8000_0000);
        send_update(MODE_BEEP, 32'h8000_0000 + 32'd199);
        send_update(MODE_BEEP, 32'h8000_0000 + 32'd200);
        send_update(MODE_BEEP, 32'h8000_0000 + 32'd399);
        send_update(MODE_BEEP, 32'h8000_0000 + 32'd400);
        send_update(8'd3, 32'h7FFF_FFFF);
        send_update(8'd128, 32'h0000_0001);
        send_update(8'd255, 32'hFFFF_FFFF);
        send_update(8'd0, 32'h5555_AAAA);
    endtask

    task automatic test_register_extremes();
        // zero halves, zero base, zero frequencies
        load_settings(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 24'd0);
        send_update(MODE_SIREN, 32'd7);
        send_update(MODE_SIREN, 32'd8);
        send_update(MODE_BEEP, 32'd9);
        send_update(MODE_BEEP, 32'd10);
        // inverted limits below the floor, largest base, largest halves
        load_settings(16'd50, 16'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
        send_update(MODE_SIREN, 32'h0001_0000);
        send_update(MODE_SIREN, 32'h0002_0000);
        send_update(MODE_BEEP, 32'hAAAA_5555);
        send_update(MODE_BEEP, 32'hAAAB_5554);
    endtask

    task automatic test_random_traffic();
        // no idling, reset-like settings
        idle_pct = 0;
        stall_pct = 0;
        load_settings(SWEEP_LOW_RST, SWEEP_HIGH_RST, BEEP_HZ_RST, 16'd40, 16'd9,
                      TIMER_BASE_RST);
        run_traffic(95);
        // sender idling, small random settings
        load_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 4000)),
                      16'($urandom_range(50, 3000)), 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 40)), 24'($urandom_range(5000, 600000)));
        idle_pct = 45;
        stall_pct = 0;
        run_traffic(95);
        // receiver stalling, full-range random frequencies and base, halves up to 300
        load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                      24'($urandom()));
        idle_pct = 0;
        stall_pct = 45;
        run_traffic(95);
        // both sides idling, widest sweep
        load_settings(16'd0, 16'hFFFF, 16'd100, 16'd700, 16'd1, 24'hFF_FFFF);
        idle_pct = 17;
        stall_pct = 17;
        run_traffic(95);
        drain_results();
    endtask

    always @(negedge i_clk) begin
        tone_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_tone exp_tone;
        if (i_rst_n && tone_if.valid && tone_if.ready) begin
            if (tone_queue.size() == 0) begin
                $display("%0t unexpected result tone_on %0b compare %0d", $time,
                         tone_if.tone_on, tone_if.compare_value);
                errors++;
            end else begin
                exp_tone = tone_queue.pop_front();
                tones_checked++;
                if (tone_if.tone_on !== exp_tone.tone_on) begin
                    $display("%0t tone_on expected %0b got %0b", $time,
                             exp_tone.tone_on, tone_if.tone_on);
                    errors++;
                end
                if (tone_if.compare_value !== exp_tone.compare_value) begin
                    $display("%0t compare_value expected %0d got %0d", $time,
                             exp_tone.compare_value, tone_if.compare_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (upd_if.valid && upd_if.ready) || (tone_if.valid && tone_if.ready)
                || (reg_if.valid && reg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        upd_if.valid      = 1'b0;
        upd_if.alarm_mode = 8'd0;
        upd_if.now_ms     = 32'd0;
        reg_if.valid      = 1'b0;
        reg_if.index      = REG_SWEEP_LOW;
        reg_if.data       = 24'd0;
        idle_pct          = 0;
        stall_pct         = 0;
        errors            = 0;
        updates_sent      = 0;
        tones_checked     = 0;
        reg_writes        = 0;
        low_hz            = SWEEP_LOW_RST;
        high_hz           = SWEEP_HIGH_RST;
        beep_tone_hz      = BEEP_HZ_RST;
        sweep_half        = SWEEP_HALF_RST;
        beep_half         = BEEP_HALF_RST;
        base_hz           = TIMER_BASE_RST;
        seen_mode         = LAST_MODE_RST;
        mode_origin_ms    = 32'd0;
        held_compare      = COMPARE_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sweep_and_beep();
        test_register_extremes();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d updates sent, %0d results checked, %0d register writes",
                 updates_sent, tones_checked, reg_writes);
        $display("summary: siren, beep and silent modes under four idle/stall mixes");
        if (errors == 0 && tone_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, tone_queue.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
